### hw/rtl/aids_pkg.sv
// aids_pkg: shared types and codes for the array insert/delete shift unit
// no dependencies; imported by aids_cell and array_insert_delete_shift_unit
`default_nettype none

package aids_pkg;

	// fixed field widths
	localparam int OP_W    = 3;
	localparam int POS_W   = 5;
	localparam int VAL_W   = 32;
	localparam int STAT_W  = 2;
	localparam int CNT_W   = 5;
	localparam int IN_DW   = 40;
	localparam int OUT_DW  = 40;

	// operation codes
	localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
	localparam logic [OP_W-1:0] OP_INS_END   = 3'd1;
	localparam logic [OP_W-1:0] OP_INS_POS   = 3'd2;
	localparam logic [OP_W-1:0] OP_DEL_FRONT = 3'd3;
	localparam logic [OP_W-1:0] OP_DEL_END   = 3'd4;
	localparam logic [OP_W-1:0] OP_DEL_POS   = 3'd5;

	// status codes
	localparam logic [STAT_W-1:0] ST_DONE   = 2'd0;
	localparam logic [STAT_W-1:0] ST_BADPOS = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd2;
	localparam logic [STAT_W-1:0] ST_FULL   = 2'd3;

	// reset value of the capacity register
	localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;

	// per-cell move command
	typedef struct packed {
		logic load;   // take the new value
		logic up;     // take the left neighbor (insert shift)
		logic down;   // take the right neighbor (delete shift)
	} aids_ctrl_t;

endpackage

`default_nettype wire

### hw/rtl/array_insert_delete_shift_unit.sv
// array_insert_delete_shift_unit: ordered array with insert/delete at any place
// depends on aids_pkg and aids_cell
//
// usage:
//   s_axis carries one operation per item (op, position, new_value). every
//   item gives exactly one result item on m_axis (status, removed_value,
//   count_after). the array is a row of DEPTH cells; an insert moves every
//   cell above the target one place up and a delete moves every cell at or
//   above the target one place down, all in the same clock edge.
//   the result is valid in the cycle after the input is accepted. throughput: one
//   item per cycle while the receiver takes results; the whole array shift and the
//   combinational status check set that figure.
//   the result sits in one output register; a new item is taken while that
//   register is empty or is being taken in the same cycle, so a stalled
//   receiver holds the input after one item.
//   cfg carries capacity_limit; it is always ready. write it only while idle;
//   the block does not enforce that. values above DEPTH act as DEPTH, zero
//   makes every insert report full. reset: count to zero, capacity to 16,
//   output empty; cells are not cleared, only entries below the count are read.
`default_nettype none

module array_insert_delete_shift_unit #(
	parameter int DEPTH = 16
) (
	input  wire                            clk,
	input  wire                            arst_n,
	// input items
	input  wire                            s_axis_tvalid,
	output logic                           s_axis_tready,
	input  wire  [aids_pkg::IN_DW-1:0]     s_axis_tdata,  // op[2:0], position[7:3], new_value[39:8]
	// result items
	output logic                           m_axis_tvalid,
	input  wire                            m_axis_tready,
	output logic [aids_pkg::OUT_DW-1:0]    m_axis_tdata,  // status[1:0], removed_value[33:2], count_after[38:34], zero[39]
	// configuration
	input  wire                            cfg_valid,
	output logic                           cfg_ready,
	input  wire  [aids_pkg::CNT_W-1:0]     cfg_data       // capacity_limit[4:0]
);
	import aids_pkg::*;

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int XW = (IW > POS_W) ? IW : POS_W;
	localparam logic [CNT_W-1:0] DEPTH_CAP = (DEPTH > 31) ? 5'd31 : CNT_W'(DEPTH);

	logic [CNT_W-1:0]  capacity_q;
	logic [CNT_W-1:0]  count_q;
	logic              out_valid_q;
	logic [OUT_DW-1:0] out_data_q;

	logic [OP_W-1:0]   op;
	logic [POS_W-1:0]  position;
	logic [VAL_W-1:0]  new_value;
	logic              accept;
	logic              is_ins;
	logic              is_del;
	logic [POS_W-1:0]  eff_pos;
	logic [XW-1:0]     eff_pos_x;
	logic [CNT_W-1:0]  room;
	logic [STAT_W-1:0] status;
	logic              ins_go;
	logic              del_go;
	logic [CNT_W-1:0]  count_next;
	logic [VAL_W-1:0]  removed;

	logic [VAL_W-1:0]  cell_q  [DEPTH];
	logic              cell_eq [DEPTH];
	logic              cell_gt [DEPTH];
	aids_ctrl_t        cell_ctrl [DEPTH];

	// unpack input item
	assign op        = s_axis_tdata[2:0];
	assign position  = s_axis_tdata[7:3];
	assign new_value = s_axis_tdata[39:8];

	// handshakes
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// effective capacity
	assign room = (capacity_q > DEPTH_CAP) ? DEPTH_CAP : capacity_q;

	// operation class and target position
	always_comb begin
		is_ins  = 1'b0;
		is_del  = 1'b0;
		eff_pos = '0;
		case (op)
			OP_INS_FRONT: begin
				is_ins = 1'b1;
			end
			OP_INS_END: begin
				is_ins  = 1'b1;
				eff_pos = count_q;
			end
			OP_INS_POS: begin
				is_ins  = 1'b1;
				eff_pos = position;
			end
			OP_DEL_FRONT: begin
				is_del = 1'b1;
			end
			OP_DEL_END: begin
				is_del  = 1'b1;
				eff_pos = count_q - 5'd1;
			end
			OP_DEL_POS: begin
				is_del  = 1'b1;
				eff_pos = position;
			end
			default: begin
				is_ins = 1'b0;
			end
		endcase
	end

	assign eff_pos_x = XW'(eff_pos);

	// status check: full/empty before position
	always_comb begin
		status = ST_BADPOS;
		if (is_ins) begin
			if (count_q >= room) begin
				status = ST_FULL;
			end else if (eff_pos > count_q) begin
				status = ST_BADPOS;
			end else begin
				status = ST_DONE;
			end
		end else if (is_del) begin
			if (count_q == '0) begin
				status = ST_EMPTY;
			end else if (eff_pos >= count_q) begin
				status = ST_BADPOS;
			end else begin
				status = ST_DONE;
			end
		end
	end

	assign ins_go = accept && is_ins && (status == ST_DONE);
	assign del_go = accept && is_del && (status == ST_DONE);

	always_comb begin
		count_next = count_q;
		if (ins_go) begin
			count_next = count_q + 5'd1;
		end else if (del_go) begin
			count_next = count_q - 5'd1;
		end
	end

	// the row of cells with per-cell position decode
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		localparam logic [XW-1:0] IDX = XW'(i);
		logic [VAL_W-1:0] left_value;
		logic [VAL_W-1:0] right_value;

		assign cell_eq[i] = (IDX == eff_pos_x);
		assign cell_gt[i] = (IDX > eff_pos_x);

		assign cell_ctrl[i].load = ins_go && cell_eq[i];
		assign cell_ctrl[i].up   = ins_go && cell_gt[i];
		assign cell_ctrl[i].down = del_go && (cell_eq[i] || cell_gt[i]);

		if (i == 0) begin : g_first
			assign left_value = new_value;
		end else begin : g_mid
			assign left_value = cell_q[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_value = cell_q[i];
		end else begin : g_body
			assign right_value = cell_q[i+1];
		end

		aids_cell u_cell (
			.clk         (clk),
			.ctrl        (cell_ctrl[i]),
			.new_value   (new_value),
			.left_value  (left_value),
			.right_value (right_value),
			.value_q     (cell_q[i])
		);
	end

	// removed value: pick the target cell on a good delete
	always_comb begin
		removed = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (cell_eq[i]) begin
				removed = removed | cell_q[i];
			end
		end
		if (!(is_del && (status == ST_DONE))) begin
			removed = '0;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q  <= CAP_RESET;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				capacity_q <= cfg_data;
			end
			count_q <= count_next;
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q <= {1'b0, count_next, removed, status};
		end
	end

`ifndef SYNTH
	// count never passes the row length
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_CAP)
		else $error("element count beyond array depth");

	// a good insert grows the count by one
	a_ins_count: assert property (@(posedge clk) disable iff (!arst_n)
		ins_go |=> (count_q == $past(count_q) + 5'd1))
		else $error("insert did not grow the count");

	// a rejected item reports zero removed and the count it found
	a_reject_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (status != ST_DONE)) |=>
		(m_axis_tdata[33:2] == '0) && (m_axis_tdata[38:34] == count_q))
		else $error("rejected item changed state or value");

	// a full output register that is stalled blocks the input
	a_stall_block: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
		else $error("input taken while result stalled");
`endif

endmodule

`default_nettype wire

### hw/rtl/aids_cell.sv
// aids_cell: one storage cell of the shifting array
// depends on aids_pkg for the move command struct
`default_nettype none

module aids_cell (
	input  wire                            clk,
	input  wire  aids_pkg::aids_ctrl_t     ctrl,
	input  wire  [aids_pkg::VAL_W-1:0]     new_value,
	input  wire  [aids_pkg::VAL_W-1:0]     left_value,
	input  wire  [aids_pkg::VAL_W-1:0]     right_value,
	output logic [aids_pkg::VAL_W-1:0]     value_q
);
	import aids_pkg::*;

	// entry register, moved by neighbor handoff
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			value_q <= new_value;
		end else if (ctrl.up) begin
			value_q <= left_value;
		end else if (ctrl.down) begin
			value_q <= right_value;
		end
	end

endmodule

`default_nettype wire
